// ----- sv/fdrc_pkg.sv -----
// ----------------------------------------------------------------------------
// fdrc_pkg : shared types, constants and lookup tables
// Widths, fixed-point constants, the log2 and exp2 tables and the request
// structures passed between the compressor's sub-units.
// ----------------------------------------------------------------------------
package fdrc_pkg;

  // Sample and table geometry
  localparam int SAMPLE_BITS = 24;
  localparam int TAB_BITS    = 8;
  localparam int TAB_SIZE    = 1 << TAB_BITS;
  localparam int LZ_W        = 5;             // leading-zero count, up to SAMPLE_BITS-1
  localparam int NORM_STEPS  = 5;             // binary search: 16, 8, 4, 2, 1
  localparam int STEP_W      = 3;

  // Datapath widths
  localparam int DB_W     = 17;               // signed Q8.8 level / threshold
  localparam int COEF_W   = 16;               // Q0.16 coefficients
  localparam int SM_W     = 24;               // smoothed reduction, Q9.15
  localparam int FRAC_W   = 16;
  localparam int GAIN_W   = 31;               // Q1.30 gain
  localparam int MUL_A_W  = 24;
  localparam int MUL_B_W  = 31;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int P_W      = 23;               // gain exponent, Q7.16
  localparam int GRD_W    = 16;

  // Fixed-point constants
  localparam logic [MUL_B_W-1:0]    DB_PER_OCT  = 31'd394566;  // 20log10(2), Q16
  localparam logic [MUL_B_W-1:0]    OCT_PER_DB  = 31'd10885;   // log2(10)/20, Q16
  localparam logic signed [DB_W-1:0] FLOOR_DB   = -17'sd61440; // -240 dB
  localparam logic [DB_W-1:0]       UNITY_Q16   = 17'h10000;
  localparam int                    GAIN_CUT    = 26;          // exponent giving zero

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_REC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd3;

  // Reset values of the configuration registers
  localparam logic signed [DB_W-1:0] THRESHOLD_RST = -17'sd5120;
  localparam logic [COEF_W-1:0]      RATIO_REC_RST = 16'd32768;
  localparam logic [COEF_W-1:0]      ATTACK_RST    = 16'd65000;
  localparam logic [COEF_W-1:0]      RELEASE_RST   = 16'd65500;

  // Request to the shared multiplier
  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  // Status of the normaliser
  typedef struct packed {
    logic                busy;
    logic [LZ_W-1:0]     lz;
    logic [TAB_BITS-1:0] idx;
  } norm_stat_t;

  typedef logic [FRAC_W-1:0] log_tab_t [TAB_SIZE];
  typedef logic [GAIN_W-1:0] exp_tab_t [TAB_SIZE];

  // Integer square root, bit-by-bit, for table construction only
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = val;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/2^TAB_BITS) in Q0.16 by repeated Q30 squaring
  function automatic log_tab_t build_log_tab();
    log_tab_t          t;
    logic [63:0]       v;
    logic [FRAC_W-1:0] frac;
    for (int i = 0; i < TAB_SIZE; i++) begin
      v    = (64'd1 << 30) + (64'(i) << (30 - TAB_BITS));
      frac = '0;
      for (int k = 0; k < FRAC_W; k++) begin
        v    = (v * v + (64'd1 << 29)) >> 30;
        frac = {frac[FRAC_W-2:0], 1'b0};
        if (v >= (64'd1 << 31)) begin
          v       = v >> 1;
          frac[0] = 1'b1;
        end
      end
      t[i] = frac;
    end
    return t;
  endfunction

  // 2^(-i/2^TAB_BITS) in Q1.30 as a product of successive square roots
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] g;
    logic [63:0] root;
    for (int i = 0; i < TAB_SIZE; i++) begin
      g    = 64'd1 << 30;
      root = isqrt64(64'd1 << 59);
      for (int k = 1; k <= TAB_BITS; k++) begin
        if (((i >> (TAB_BITS - k)) & 1) != 0)
          g = (g * root + (64'd1 << 29)) >> 30;
        root = isqrt64(root << 30);
      end
      t[i] = g[GAIN_W-1:0];
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ----- sv/fdrc_mul.sv -----
// ----------------------------------------------------------------------------
// fdrc_mul : shared multiplier
// One unsigned multiplier used for every product of the datapath; the
// product is registered and held until the next request.
// ----------------------------------------------------------------------------
module fdrc_mul (
  input  logic                      clk,
  input  fdrc_pkg::mul_req_t        req,
  output logic [fdrc_pkg::PROD_W-1:0] prod_r
);
  import fdrc_pkg::*;

  // Registered product, held while idle
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

endmodule

// ----- sv/fdrc_norm.sv -----
// ----------------------------------------------------------------------------
// fdrc_norm : iterative normaliser
// Finds the leading one of a non-zero magnitude by a five-step binary
// search and returns the leading-zero count and the table index below it.
// ----------------------------------------------------------------------------
module fdrc_norm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [fdrc_pkg::SAMPLE_BITS-1:0]  mag,
  output fdrc_pkg::norm_stat_t              stat
);
  import fdrc_pkg::*;

  logic                   busy_r, busy_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [SAMPLE_BITS-1:0] norm_r, norm_nxt;
  logic [LZ_W-1:0]        lz_r, lz_nxt;
  logic [LZ_W:0]          amt;
  logic                   top_zero;

  // Shift amount halves each step; test whether the top bits are clear
  always_comb begin
    amt      = (LZ_W + 1)'(SAMPLE_BITS'(16) >> step_r);
    top_zero = ((norm_r >> (SAMPLE_BITS - int'(amt))) == '0);
  end

  // Next state
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    norm_nxt = norm_r;
    lz_nxt   = lz_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      norm_nxt = mag;
      lz_nxt   = '0;
    end else if (busy_r) begin
      if (top_zero) begin
        norm_nxt = norm_r << amt;
        lz_nxt   = lz_r + LZ_W'(amt);
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(NORM_STEPS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    norm_r <= norm_nxt;
    lz_r   <= lz_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.lz   = lz_r;
  assign stat.idx  = norm_r[SAMPLE_BITS-2 -: TAB_BITS];

endmodule

// ----- sv/feedforward_dynamic_range_compressor_unit.sv -----
// ----------------------------------------------------------------------------
// feedforward_dynamic_range_compressor_unit : hard-knee audio compressor
// Level detection in dB, hard-knee gain computer, one-pole attack/release
// smoothing and exp2-based gain, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: a non-zero sample passes through the five-step normaliser,
//   then the log, threshold, smoothing and gain steps; a zero sample
//   skips the normalising pass. A new sample is accepted only while idle,
//   after the previous result is loaded, with up to six passes through
//   the shared multiplier; a stalled result register holds the last step.
// Reset (rst_n, synchronous): configuration returns to its defaults, the
//   smoothed reduction clears to zero and both channels go empty.
// ----------------------------------------------------------------------------
module feedforward_dynamic_range_compressor_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdrc_pkg::DB_W-1:0]           cfg_data,
  // input samples
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fdrc_pkg::SAMPLE_BITS-1:0] in_sample_in,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fdrc_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic [fdrc_pkg::GRD_W-1:0]          out_gain_reduction_db
);
  import fdrc_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_LOG  = 4'd2;
  localparam logic [3:0] S_LVL  = 4'd3;
  localparam logic [3:0] S_THR  = 4'd4;
  localparam logic [3:0] S_RED  = 4'd5;
  localparam logic [3:0] S_SM1  = 4'd6;
  localparam logic [3:0] S_SM2  = 4'd7;
  localparam logic [3:0] S_SM3  = 4'd8;
  localparam logic [3:0] S_GP   = 4'd9;
  localparam logic [3:0] S_GN   = 4'd10;
  localparam logic [3:0] S_GM   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0] state_r, state_nxt;

  // Configuration registers
  logic signed [DB_W-1:0] thr_r;
  logic [COEF_W-1:0]      rrec_r, att_r, rel_r;

  // Working registers
  logic [SAMPLE_BITS-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic signed [DB_W-1:0] xg_r, xg_nxt;
  logic [SM_W-1:0]        red_r, red_nxt;
  logic [COEF_W-1:0]      c_r, c_nxt;
  logic [PROD_W-1:0]      acc_r, acc_nxt;
  logic [SM_W-1:0]        sm_r, sm_nxt;
  logic [P_W-1:0]         p_r, p_nxt;

  // Output registers
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_smp_r, out_smp_nxt;
  logic [GRD_W-1:0]              out_grd_r, out_grd_nxt;

  // Shared units
  mul_req_t          mreq;
  logic [PROD_W-1:0] prod_r;
  norm_stat_t        nstat;
  logic              norm_start;
  logic [SAMPLE_BITS-1:0] in_mag;
  logic              in_acc;

  fdrc_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  fdrc_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .mag   (in_mag),
    .stat  (nstat)
  );

  // Handshakes
  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign in_mag     = in_sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_sample_in)
                                                  : SAMPLE_BITS'(in_sample_in);
  assign norm_start = in_acc && (in_mag != '0);

  // Datapath helpers
  logic [LZ_W+FRAC_W-1:0]   lvl_neg;
  logic [FRAC_W-1:0]        lvl_db;
  logic signed [DB_W:0]     excess;
  logic [DB_W-1:0]          red_q88;
  logic [PROD_W:0]          sm_sum;
  logic [PROD_W-1:0]        p_sum;
  logic [COEF_W-1:0]        c_sel;
  logic [6:0]               gexp;
  logic [PROD_W-1:0]        g_shift;
  logic [SAMPLE_BITS+1:0]   g_round;
  logic [SAMPLE_BITS:0]     g_lim;
  logic [SAMPLE_BITS-1:0]   g_res;
  logic [SM_W-GRD_W+GRD_W:0] grd_sum;

  always_comb begin
    lvl_neg = {nstat.lz, {FRAC_W{1'b0}}} - (LZ_W + FRAC_W)'(LOG_TAB[nstat.idx]);
    lvl_db  = FRAC_W'((prod_r + (PROD_W'(1) << 23)) >> 24);
    excess  = (DB_W + 1)'(xg_r) - (DB_W + 1)'(thr_r);
    red_q88 = DB_W'((prod_r + PROD_W'(32768)) >> 16);
    c_sel   = (red_r > sm_r) ? att_r : rel_r;
    sm_sum  = (PROD_W + 1)'(acc_r) + (PROD_W + 1)'(prod_r) + (PROD_W + 1)'(32768);
    p_sum   = (prod_r + (PROD_W'(1) << 14)) >> 15;
    // Gain shift with rounding, then saturation and sign
    gexp    = p_r[P_W-1:FRAC_W];
    g_shift = prod_r >> (29 + int'(gexp));
    g_round = (SAMPLE_BITS + 2)'(((SAMPLE_BITS + 2)'(g_shift) + 1'b1) >> 1);
    if (gexp >= 7'(GAIN_CUT)) g_round = '0;
    g_lim   = neg_r ? (SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 1)
                    : ((SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 1)) - 1'b1;
    g_res   = (g_round > (SAMPLE_BITS + 2)'(g_lim)) ? SAMPLE_BITS'(g_lim)
                                                    : SAMPLE_BITS'(g_round);
    grd_sum = (SM_W + 1)'(sm_r) + (SM_W + 1)'(64);
  end

  // Sequencer and multiplier requests
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    xg_nxt        = xg_r;
    red_nxt       = red_r;
    c_nxt         = c_r;
    acc_nxt       = acc_r;
    sm_nxt        = sm_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r;
    out_smp_nxt   = out_smp_r;
    out_grd_nxt   = out_grd_r;
    mreq          = '0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mag_nxt = in_mag;
          neg_nxt = in_sample_in[SAMPLE_BITS-1];
          if (in_mag == '0) begin
            xg_nxt    = FLOOR_DB;
            state_nxt = S_THR;
          end else begin
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (!nstat.busy) state_nxt = S_LOG;
      end
      S_LOG: begin
        // |log2| in Q16 times dB per octave
        mreq.en   = 1'b1;
        mreq.a    = MUL_A_W'(lvl_neg);
        mreq.b    = DB_PER_OCT;
        state_nxt = S_LVL;
      end
      S_LVL: begin
        xg_nxt    = DB_W'(-(DB_W'(lvl_db)));
        state_nxt = S_THR;
      end
      S_THR: begin
        // hard knee: reduction only above threshold
        if (xg_r > thr_r) begin
          mreq.en   = 1'b1;
          mreq.a    = MUL_A_W'(excess[DB_W-1:0]);
          mreq.b    = MUL_B_W'(UNITY_Q16 - DB_W'(rrec_r));
          state_nxt = S_RED;
        end else begin
          red_nxt   = '0;
          state_nxt = S_SM1;
        end
      end
      S_RED: begin
        red_nxt   = {red_q88, 7'b0};
        state_nxt = S_SM1;
      end
      S_SM1: begin
        c_nxt     = c_sel;
        mreq.en   = 1'b1;
        mreq.a    = sm_r;
        mreq.b    = MUL_B_W'(c_sel);
        state_nxt = S_SM2;
      end
      S_SM2: begin
        acc_nxt   = prod_r;
        mreq.en   = 1'b1;
        mreq.a    = red_r;
        mreq.b    = MUL_B_W'(UNITY_Q16 - DB_W'(c_r));
        state_nxt = S_SM3;
      end
      S_SM3: begin
        sm_nxt    = sm_sum[16 +: SM_W];
        state_nxt = S_GP;
      end
      S_GP: begin
        // reduction in octaves
        mreq.en   = 1'b1;
        mreq.a    = sm_r;
        mreq.b    = OCT_PER_DB;
        state_nxt = S_GN;
      end
      S_GN: begin
        p_nxt     = P_W'(p_sum);
        state_nxt = S_GM;
      end
      S_GM: begin
        mreq.en   = 1'b1;
        mreq.a    = mag_r;
        mreq.b    = EXP_TAB[p_r[FRAC_W-1 -: TAB_BITS]];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // load the result register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_smp_nxt   = neg_r ? SAMPLE_BITS'(-g_res) : g_res;
          out_grd_nxt   = (grd_sum[SM_W:7] > (SM_W - 6)'(16'hFFFF)) ? 16'hFFFF
                                                                    : grd_sum[7 +: GRD_W];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sm_r        <= '0;
      thr_r       <= THRESHOLD_RST;
      rrec_r      <= RATIO_REC_RST;
      att_r       <= ATTACK_RST;
      rel_r       <= RELEASE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sm_r        <= sm_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_THRESHOLD: thr_r  <= cfg_data;
          CFG_RATIO_REC: rrec_r <= cfg_data[COEF_W-1:0];
          CFG_ATTACK:    att_r  <= cfg_data[COEF_W-1:0];
          CFG_RELEASE:   rel_r  <= cfg_data[COEF_W-1:0];
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    xg_r      <= xg_nxt;
    red_r     <= red_nxt;
    c_r       <= c_nxt;
    acc_r     <= acc_nxt;
    p_r       <= p_nxt;
    out_smp_r <= out_smp_nxt;
    out_grd_r <= out_grd_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_sample_out        = out_smp_r;
  assign out_gain_reduction_db = out_grd_r;

  // Checks
  a_norm_in_norm_state: assert property (@(posedge clk) disable iff (!rst_n)
    nstat.busy |-> (state_r == S_NORM))
    else $error("normaliser busy outside its state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("transaction accepted but sequencer stayed idle");

  a_smooth_only_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SM3) |=> $stable(sm_r))
    else $error("smoothed reduction changed outside the update step");

endmodule
